FILE: rtl/tmel_pkg.sv
// Shared types, constants and register codes of the truncated mean energy loss block.
package tmel_pkg;

  // Default sizing of the sample store.
  localparam int MAX_SAMPLES_DEF = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // Register reset values and widths.
  localparam int          LOW_W      = 8;
  localparam int          HIGH_W     = 9;
  localparam logic [7:0]  LOW_RESET  = 8'd13;
  localparam logic [8:0]  HIGH_RESET = 9'd179;

  // Register indexes, selected by paddr[2].
  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  // Fields of one input transfer.
  typedef struct packed {
    logic [15:0] sample_value;
    logic        last_sample;
  } in_item_t;

  // Fields of one result transfer.
  typedef struct packed {
    logic [15:0] mean_value;
    logic        empty_track;
    logic        overflowed;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_RANK,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/tmel_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tmel_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tmel_div.sv
// Restoring divider that produces one quotient bit per cycle.
module tmel_div #(
  parameter int DW = 25,
  parameter int VW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? diff[VW-1:0] : shifted[VW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/truncated_mean_energy_loss_top.sv
// Top level of the truncated mean energy loss block: sorted sample store, sequencer and divider.
// A sample into an empty store is written directly; otherwise each larger stored sample is moved up one place first.
// The sample marked last is followed by the rank step, a sum over the windowed samples, the divide
// and the result load; an empty track goes from the rank step straight to the result load.
// One item at a time; the single sorted memory port pair sets the insertion rate.
// Reset clears the sample count, overflow flag and sequencer; memory content is not cleared.
module truncated_mean_energy_loss_top
  import tmel_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [SAMPLE_BITS-1:0] v_q, v_d;
  logic                   last_q, last_d;
  logic [AW-1:0]          lo_q, lo_d, hi_q, hi_d, addr_q, addr_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [15:0]            mean_q, mean_d;
  logic                   empty_q, empty_d;
  out_item_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;
  logic [LOW_W-1:0]       low_q;
  logic [HIGH_W-1:0]      high_q;

  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [SAMPLE_BITS-1:0] wdata, rdata;
  logic [SAMPLE_BITS-1:0] sample;

  logic [LOW_W+CNT_W-1:0]  p_lo;
  logic [HIGH_W+CNT_W-1:0] p_hi;
  logic [CNT_W-1:0]        lo_raw, nm1, hi_c, lo_c;
  logic [CNT_W:0]          hi_raw;

  logic                    div_start, div_done;
  logic [SUM_W-1:0]        quotient;
  logic [CNT_W-1:0]        divisor;

  // Configuration port: writes on the access phase, reads return the register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RESET;
      high_q <= HIGH_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_LOW:  low_q  <= pwdata[LOW_W-1:0];
        REG_HIGH: high_q <= pwdata[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LOW:  prdata = {{(32-LOW_W){1'b0}}, low_q};
      REG_HIGH: prdata = {{(32-HIGH_W){1'b0}}, high_q};
      default:  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Sorted sample store.
  tmel_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Window mean divider.
  tmel_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Rank window from the fractions and the sample count.
  always_comb begin
    p_lo   = (LOW_W + CNT_W)'(low_q) * (LOW_W + CNT_W)'(count_q);
    p_hi   = (HIGH_W + CNT_W)'(high_q) * (HIGH_W + CNT_W)'(count_q);
    lo_raw = p_lo[LOW_W+CNT_W-1:8];
    hi_raw = p_hi[HIGH_W+CNT_W-1:8];
    nm1    = count_q - CNT_W'(1);
    hi_c   = (hi_raw > {1'b0, nm1}) ? nm1 : hi_raw[CNT_W-1:0];
    lo_c   = (lo_raw > hi_c) ? hi_c : lo_raw;
  end

  assign sample  = SAMPLE_BITS'(in_data_i.sample_value);
  assign divisor = CNT_W'(hi_q) - CNT_W'(lo_q) + CNT_W'(1);

  // Sequencer: insertion by read-compare-write, then window sum and divide.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    v_d         = v_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    addr_d      = addr_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    empty_d     = empty_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          v_d    = sample;
          last_d = in_data_i.last_sample;
          if (count_q < CNT_W'(MAX_SAMPLES)) begin
            if (count_q == '0) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = sample;
              count_d = CNT_W'(1);
              state_d = in_data_i.last_sample ? ST_RANK : ST_IDLE;
            end else begin
              re      = 1'b1;
              raddr   = AW'(count_q - CNT_W'(1));
              pos_d   = AW'(count_q);
              state_d = ST_INS;
            end
          end else begin
            ovf_d   = 1'b1;
            state_d = in_data_i.last_sample ? ST_RANK : ST_IDLE;
          end
        end
      end
      ST_INS: begin
        we = 1'b1;
        waddr = pos_q;
        if (pos_q != '0 && rdata > v_q) begin
          // Move the larger neighbor up one place and look further down.
          wdata = rdata;
          pos_d = pos_q - AW'(1);
          if (pos_q != AW'(1)) begin
            re    = 1'b1;
            raddr = pos_q - AW'(2);
          end
        end else begin
          wdata   = v_q;
          count_d = count_q + CNT_W'(1);
          state_d = last_q ? ST_RANK : ST_IDLE;
        end
      end
      ST_RANK: begin
        if (count_q == '0) begin
          mean_d  = '0;
          empty_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          lo_d    = AW'(lo_c);
          hi_d    = AW'(hi_c);
          addr_d  = AW'(lo_c);
          re      = 1'b1;
          raddr   = AW'(lo_c);
          sum_d   = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d = sum_q + SUM_W'(rdata);
        if (addr_q == hi_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          addr_d = addr_q + AW'(1);
          re     = 1'b1;
          raddr  = addr_q + AW'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mean_d  = 16'(quotient);
          empty_d = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Load the result once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_d.mean_value  = mean_q;
          out_d.empty_track = empty_q;
          out_d.overflowed  = ovf_q;
          out_valid_d       = 1'b1;
          count_d           = '0;
          ovf_d             = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    v_q     <= v_d;
    last_q  <= last_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    addr_q  <= addr_d;
    sum_q   <= sum_d;
    mean_q  <= mean_d;
    empty_q <= empty_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The store never holds more samples than it has room for.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count above capacity");

  // The insertion point never lies beyond the slot just past the stored samples.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INS |-> CNT_W'(pos_q) <= count_q)
    else $error("insertion point beyond stored samples");

  // The window walk stays between the lower and upper ranks.
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM |-> (lo_q <= addr_q) && (addr_q <= hi_q))
    else $error("window address outside rank window");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside divide state");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench of the truncated mean energy loss block.
`timescale 1ns / 100ps

module testbench;
  import tmel_pkg::*;

  localparam int DEPTH = 256;
  localparam longint CYCLE_LIMIT = 4000000;

  // Running prediction of the block: sorted track store, registers, expected results.
  class track_mean_board;
    logic [15:0] sorted_q[$];
    bit          dropped;
    logic [7:0]  low_frac;
    logic [8:0]  high_frac;
    out_item_t   pending_q[$];
    int          mismatches;

    function new();
      low_frac = LOW_RESET;
      high_frac = HIGH_RESET;
      dropped = 0;
      mismatches = 0;
    endfunction

    // Store the sample in order and, on the last mark, predict the mean.
    function void note_sample(in_item_t it);
      int pos;
      int n;
      int lo;
      int hi;
      longint sum;
      out_item_t res;
      if (sorted_q.size() < DEPTH) begin
        pos = sorted_q.size();
        while (pos > 0 && sorted_q[pos-1] > it.sample_value) pos--;
        sorted_q.insert(pos, it.sample_value);
      end else begin
        dropped = 1;
      end
      if (!it.last_sample) return;
      n = sorted_q.size();
      lo = (int'(low_frac) * n) >> 8;
      hi = (int'(high_frac) * n) >> 8;
      if (hi > n - 1) hi = n - 1;
      if (lo > hi) lo = hi;
      sum = 0;
      for (int i = lo; i <= hi; i++) sum += sorted_q[i];
      res.mean_value = 16'(sum / (hi - lo + 1));
      res.empty_track = (n == 0);
      res.overflowed = dropped;
      pending_q.push_back(res);
      sorted_q.delete();
      dropped = 0;
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result: mean_value %0d", got.mean_value);
        mismatches++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.mean_value !== exp_r.mean_value) begin
        $error("mean_value: expected %0d, got %0d", exp_r.mean_value, got.mean_value);
        mismatches++;
      end
      if (got.empty_track !== exp_r.empty_track) begin
        $error("empty_track: expected %0b, got %0b", exp_r.empty_track, got.empty_track);
        mismatches++;
      end
      if (got.overflowed !== exp_r.overflowed) begin
        $error("overflowed: expected %0b, got %0b", exp_r.overflowed, got.overflowed);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  track_mean_board board;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycle_count;

  truncated_mean_energy_loss_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle limit guard.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver side: random stall and result checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Register write through the two-phase port; the block must be idle.
  task automatic write_reg(logic idx, logic [8:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LOW) board.low_frac = value[7:0];
    else board.high_frac = value;
  endtask

  // Send one sample, idling at random beforehand, and wait for its transfer.
  // Valid stays high after the transfer until the next idle cycle or drain.
  task automatic send_sample(logic [15:0] value, logic last);
    in_item_t it;
    it.sample_value = value;
    it.last_sample = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.note_sample(it);
  endtask

  // Wait for every expected result plus the block's tail.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_track(int len, bit max_mode);
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: v = max_mode ? 16'hFFFF : 16'h0000;
        1: v = 16'($urandom_range(7));
        default: v = 16'($urandom);
      endcase
      send_sample(v, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 23;
    recv_idle_pct = 67;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single samples, extremes, equal values, reset fractions.
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    for (int i = 0; i < 8; i++) send_sample(16'(8 - i), i == 7);
    drain();
    // Full window and upper fraction above range.
    write_reg(REG_LOW, 9'd0);
    write_reg(REG_HIGH, 9'd511);
    for (int i = 0; i < 6; i++) send_sample(16'hFFFF, i == 5);
    drain();
    write_reg(REG_LOW, 9'd255);
    write_reg(REG_HIGH, 9'd0);
    random_track(5, 1);
    drain();

    // Overflow: a full store, then dropped samples, the last one marked.
    write_reg(REG_LOW, 9'd13);
    write_reg(REG_HIGH, 9'd256);
    random_track(DEPTH + 3, 1);
    drain();

    // Random tracks under several settings and idling phases.
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_LOW, 9'd13); write_reg(REG_HIGH, 9'd179); end
        1: begin write_reg(REG_LOW, 9'd0); write_reg(REG_HIGH, 9'd256); end
        2: begin
          send_idle_pct = 67; recv_idle_pct = 23;
          write_reg(REG_LOW, 9'd255); write_reg(REG_HIGH, 9'd511);
        end
        3: begin
          write_reg(REG_LOW, 9'($urandom_range(255)));
          write_reg(REG_HIGH, 9'($urandom_range(511)));
        end
        4: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          write_reg(REG_LOW, 9'd128); write_reg(REG_HIGH, 9'd128);
        end
        default: begin
          write_reg(REG_LOW, 9'($urandom_range(255)));
          write_reg(REG_HIGH, 9'($urandom_range(300)));
        end
      endcase
      for (int k = 0; k < 60; k += len) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        random_track(len, $urandom_range(1));
        sent += len;
      end
      drain();
    end

    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tmel_pkg.sv
rtl/tmel_ram.sv
rtl/tmel_div.sv
rtl/truncated_mean_energy_loss_top.sv
bench/testbench.sv
